FILE: sv/otsu_pkg.sv
// ----------------------------------------------------------------------------
// otsu_pkg : shared constants, types and helpers
// Widths of the histogram, the running sums and the exact score arithmetic.
// ----------------------------------------------------------------------------
package otsu_pkg;

  localparam int LEVELS     = 256;
  localparam int MAX_PIXELS = 1048576;

  localparam int PIX_W   = 8;
  localparam int LEVEL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CNT_W   = 21;                 // bin count, pixel total
  localparam int SUM_W   = 29;                 // intensity sum
  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam int CAP     = (MAX_PIXELS < CNT_MAX) ? MAX_PIXELS : CNT_MAX;

  // sweep arithmetic
  localparam int PROD_W = SUM_W + CNT_W;       // short multiplier product
  localparam int D_W    = PROD_W;              // |S*W1 - N*S1|
  localparam int DEN_W  = 2 * CNT_W;           // W1*W2

  // digit-serial long multiplier
  localparam int DIGIT_W   = 8;
  localparam int LM_A_W    = 2 * D_W;
  localparam int LM_B_W    = ((D_W + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
  localparam int LM_P_W    = LM_A_W + LM_B_W;
  localparam int LM_DIGITS = LM_B_W / DIGIT_W;
  localparam int LM_CNT_W  = $clog2(LM_DIGITS + 1);

  // request codes
  localparam logic ACT_ACC = 1'b0;
  localparam logic ACT_BIN = 1'b1;

  localparam logic KIND_THRESH = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  localparam logic [PIX_W-1:0] PIX_HIGH = 8'd255;
  localparam logic [PIX_W-1:0] PIX_LOW  = 8'd0;

  // sweep access to the histogram store (reads t, clears it behind)
  typedef struct packed {
    logic               rd;
    logic [LEVEL_W-1:0] addr;
  } sw_mem_t;

  // sweep outcome, held until taken
  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] level;
  } sw_res_t;

  function automatic logic [LEVEL_W-1:0] lvl_clamp(input logic [PIX_W-1:0] pix);
    logic [PIX_W:0] wide;
    wide = {1'b0, pix};
    if (wide >= (PIX_W + 1)'(LEVELS)) begin
      return LEVEL_W'(LEVELS - 1);
    end
    return LEVEL_W'(pix);
  endfunction

endpackage

FILE: sv/otsu_ram.sv
// ----------------------------------------------------------------------------
// otsu_ram : generic single-port-write, single-port-read RAM
// Registered read, old data returned on a same-address write.
// ----------------------------------------------------------------------------
module otsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/otsu_lmul.sv
// ----------------------------------------------------------------------------
// otsu_lmul : digit-serial long multiplier
// a * b, one 8-bit digit of b per cycle, MSB first; done pulses with p valid.
// ----------------------------------------------------------------------------
module otsu_lmul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [otsu_pkg::LM_A_W-1:0] a,
  input  logic [otsu_pkg::LM_B_W-1:0] b,
  output logic                        done,
  output logic [otsu_pkg::LM_P_W-1:0] p
);

  logic                                           busy;
  logic                                           pp_vld;
  logic [otsu_pkg::LM_CNT_W-1:0]                  cnt;
  logic [otsu_pkg::LM_A_W-1:0]                    a_q;
  logic [otsu_pkg::LM_B_W-1:0]                    b_q;
  logic [otsu_pkg::LM_A_W+otsu_pkg::DIGIT_W-1:0]  pp;
  logic [otsu_pkg::LM_P_W-1:0]                    acc;
  logic [otsu_pkg::DIGIT_W-1:0]                   dig;
  logic                                           issuing;

  assign dig     = b_q[otsu_pkg::LM_B_W-1 -: otsu_pkg::DIGIT_W];
  assign issuing = busy && (cnt != otsu_pkg::LM_CNT_W'(otsu_pkg::LM_DIGITS));
  assign p       = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      pp_vld <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        pp_vld <= 1'b0;
        cnt    <= '0;
      end else if (busy) begin
        if (issuing) begin
          cnt    <= cnt + 1'b1;
          pp_vld <= 1'b1;
        end else begin
          busy   <= 1'b0;
          done   <= 1'b1;
          pp_vld <= 1'b0;
        end
      end
    end
  end

  // product register, then shift-accumulate
  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      b_q <= b;
      acc <= '0;
    end else if (busy) begin
      if (issuing) begin
        pp  <= a_q * dig;
        b_q <= b_q << otsu_pkg::DIGIT_W;
      end
      if (pp_vld) begin
        acc <= (acc << otsu_pkg::DIGIT_W) + otsu_pkg::LM_P_W'(pp);
      end
    end
  end

endmodule

FILE: sv/otsu_hist.sv
// ----------------------------------------------------------------------------
// otsu_hist : histogram store and running totals
// Read-modify-write of bins with one-deep forwarding, clear pass after reset.
// ----------------------------------------------------------------------------
module otsu_hist (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        acc_req,
  input  logic [otsu_pkg::PIX_W-1:0]  pixel,
  input  logic                        clr,
  input  otsu_pkg::sw_mem_t           mem,
  output logic [otsu_pkg::CNT_W-1:0]  rd_data,
  output logic [otsu_pkg::CNT_W-1:0]  n,
  output logic [otsu_pkg::SUM_W-1:0]  s,
  output logic                        busy
);

  logic [otsu_pkg::LEVEL_W-1:0] lv;
  logic                         en;
  logic                         s1_vld;
  logic [otsu_pkg::LEVEL_W-1:0] s1_addr;
  logic                         wr_vld;
  logic [otsu_pkg::LEVEL_W-1:0] wr_addr;
  logic [otsu_pkg::CNT_W-1:0]   wr_data;
  logic [otsu_pkg::CNT_W-1:0]   inc;
  logic [otsu_pkg::LEVEL_W-1:0] clr_addr;

  logic                         ram_we;
  logic [otsu_pkg::LEVEL_W-1:0] ram_waddr;
  logic [otsu_pkg::CNT_W-1:0]   ram_wdata;
  logic [otsu_pkg::LEVEL_W-1:0] ram_raddr;

  assign lv  = otsu_pkg::lvl_clamp(pixel);
  assign en  = acc_req && (n < otsu_pkg::CNT_W'(otsu_pkg::CAP));
  // previous write not yet visible to this read
  assign inc = ((wr_vld && (wr_addr == s1_addr)) ? wr_data : rd_data) + 1'b1;

  always_comb begin
    ram_raddr = mem.rd ? mem.addr : lv;
    if (busy) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (s1_vld) begin
      ram_we    = 1'b1;
      ram_waddr = s1_addr;
      ram_wdata = inc;
    end else begin
      ram_we    = mem.rd;      // sweep zeroes the bin it reads
      ram_waddr = mem.addr;
      ram_wdata = '0;
    end
  end

  otsu_ram #(
    .WIDTH (otsu_pkg::CNT_W),
    .DEPTH (otsu_pkg::LEVELS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
      s1_vld   <= 1'b0;
      wr_vld   <= 1'b0;
      n        <= '0;
      s        <= '0;
    end else begin
      if (busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == otsu_pkg::LEVEL_W'(otsu_pkg::LEVELS - 1)) begin
          busy <= 1'b0;
        end
      end
      s1_vld <= en;
      wr_vld <= s1_vld;
      if (clr) begin
        n <= '0;
        s <= '0;
      end else if (en) begin
        n <= n + 1'b1;
        s <= s + otsu_pkg::SUM_W'(lv);
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= lv;
    wr_addr <= s1_addr;
    wr_data <= inc;
  end

endmodule

FILE: sv/otsu_sweep.sv
// ----------------------------------------------------------------------------
// otsu_sweep : threshold search sequencer
// Walks all t, exactly scores each split with no empty class, keeps first best
// ----------------------------------------------------------------------------
module otsu_sweep (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        ack,
  input  logic [otsu_pkg::CNT_W-1:0]  n,
  input  logic [otsu_pkg::SUM_W-1:0]  s,
  input  logic [otsu_pkg::CNT_W-1:0]  rd_data,
  output otsu_pkg::sw_mem_t           mem,
  output otsu_pkg::sw_res_t           res
);

  typedef enum logic [12:0] {
    SW_IDLE = 13'b0000000000001,
    SW_RD   = 13'b0000000000010,
    SW_CNT  = 13'b0000000000100,
    SW_S1   = 13'b0000000001000,
    SW_A    = 13'b0000000010000,
    SW_B    = 13'b0000000100000,
    SW_DEN  = 13'b0000001000000,
    SW_SQ   = 13'b0000010000000,
    SW_LG   = 13'b0000100000000,
    SW_LW   = 13'b0001000000000,
    SW_RG   = 13'b0010000000000,
    SW_RW   = 13'b0100000000000,
    SW_DONE = 13'b1000000000000
  } sw_state_t;

  sw_state_t state;

  logic [otsu_pkg::LEVEL_W-1:0] t;
  logic [otsu_pkg::CNT_W-1:0]   w1;
  logic [otsu_pkg::SUM_W-1:0]   s1;
  logic [otsu_pkg::SUM_W-1:0]   mul_a;
  logic [otsu_pkg::CNT_W-1:0]   mul_b;
  logic [otsu_pkg::PROD_W-1:0]  prod;
  logic [otsu_pkg::PROD_W-1:0]  a_q;
  logic [otsu_pkg::D_W-1:0]     d;
  logic [otsu_pkg::D_W-1:0]     d_next;
  logic [otsu_pkg::DEN_W-1:0]   den;
  logic [otsu_pkg::LM_A_W-1:0]  dsq;
  logic [otsu_pkg::LM_P_W-1:0]  lhs;
  logic [otsu_pkg::LM_A_W-1:0]  bsq;
  logic [otsu_pkg::DEN_W-1:0]   bden;
  logic [otsu_pkg::LEVEL_W-1:0] bt;
  logic                         skip;
  logic                         last_t;

  logic                         lm_start;
  logic [otsu_pkg::LM_A_W-1:0]  lm_a;
  logic [otsu_pkg::LM_B_W-1:0]  lm_b;
  logic                         lm_done;
  logic [otsu_pkg::LM_P_W-1:0]  lm_p;

  assign mem.rd    = (state == SW_RD);
  assign mem.addr  = t;
  assign res.done  = (state == SW_DONE);
  assign res.level = otsu_pkg::PIX_W'(bt);

  assign skip   = (w1 == '0) || (w1 >= n);      // a class is empty
  assign last_t = (t == otsu_pkg::LEVEL_W'(otsu_pkg::LEVELS - 1));
  assign d_next = (a_q >= prod) ? (a_q - prod) : (prod - a_q);

  // shared short multiplier operands
  always_comb begin
    unique case (state)
      SW_CNT: begin
        mul_a = otsu_pkg::SUM_W'(rd_data);
        mul_b = otsu_pkg::CNT_W'(t);
      end
      SW_S1: begin
        mul_a = s;
        mul_b = w1;
      end
      SW_A: begin
        mul_a = s1;
        mul_b = n;
      end
      SW_B: begin
        mul_a = otsu_pkg::SUM_W'(w1);
        mul_b = n - w1;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // long multiplier operands
  always_comb begin
    lm_start = 1'b0;
    lm_a     = '0;
    lm_b     = '0;
    unique case (state)
      SW_DEN: begin
        lm_start = 1'b1;
        lm_a     = otsu_pkg::LM_A_W'(d);
        lm_b     = otsu_pkg::LM_B_W'(d);
      end
      SW_LG: begin
        lm_start = 1'b1;
        lm_a     = dsq;
        lm_b     = otsu_pkg::LM_B_W'(bden);
      end
      SW_RG: begin
        lm_start = 1'b1;
        lm_a     = bsq;
        lm_b     = otsu_pkg::LM_B_W'(den);
      end
      default: begin
        lm_start = 1'b0;
      end
    endcase
  end

  otsu_lmul u_lmul (
    .clk   (clk),
    .rst   (rst),
    .start (lm_start),
    .a     (lm_a),
    .b     (lm_b),
    .done  (lm_done),
    .p     (lm_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SW_IDLE;
      t     <= '0;
    end else begin
      unique case (state)
        SW_IDLE: begin
          if (start) begin
            state <= SW_RD;
            t     <= '0;
          end
        end
        SW_RD:  state <= SW_CNT;
        SW_CNT: state <= SW_S1;
        SW_S1: begin
          if (skip) begin
            state <= last_t ? SW_DONE : SW_RD;
            t     <= t + 1'b1;
          end else begin
            state <= SW_A;
          end
        end
        SW_A:   state <= SW_B;
        SW_B:   state <= SW_DEN;
        SW_DEN: state <= SW_SQ;
        SW_SQ: begin
          if (lm_done) begin
            state <= SW_LG;
          end
        end
        SW_LG:  state <= SW_LW;
        SW_LW: begin
          if (lm_done) begin
            state <= SW_RG;
          end
        end
        SW_RG:  state <= SW_RW;
        SW_RW: begin
          if (lm_done) begin
            state <= last_t ? SW_DONE : SW_RD;
            t     <= t + 1'b1;
          end
        end
        SW_DONE: begin
          if (ack) begin
            state <= SW_IDLE;
          end
        end
        default: state <= SW_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if ((state == SW_IDLE) && start) begin
      w1   <= '0;
      s1   <= '0;
      bsq  <= '0;
      bden <= otsu_pkg::DEN_W'(1);
      bt   <= '0;
    end
    if (state == SW_CNT) begin
      w1 <= w1 + rd_data;
    end
    if (state == SW_S1) begin
      s1 <= s1 + otsu_pkg::SUM_W'(prod);
    end
    if (state == SW_A) begin
      a_q <= prod;                 // S*W1
    end
    if (state == SW_B) begin
      d <= d_next;                 // against N*S1
    end
    if (state == SW_DEN) begin
      den <= otsu_pkg::DEN_W'(prod);
    end
    if ((state == SW_SQ) && lm_done) begin
      dsq <= lm_p[otsu_pkg::LM_A_W-1:0];
    end
    if ((state == SW_LW) && lm_done) begin
      lhs <= lm_p;
    end
    // strict compare keeps the lowest t on ties
    if ((state == SW_RW) && lm_done && (lhs > lm_p)) begin
      bsq  <= dsq;
      bden <= den;
      bt   <= t;
    end
  end

endmodule

FILE: sv/otsu_threshold_binarizer_top.sv
// ----------------------------------------------------------------------------
// otsu_threshold_binarizer_top : histogram threshold search and binariser
// Builds a grey-level histogram, finds the split of greatest between-class
// score with exact integer arithmetic, then thresholds pixels against it.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Signals                         Carries
//  -------  ---  ------------------------------  ---------------------------
//  s_       in   tvalid tready tdata tuser tlast  pixel, action, last
//  m_       out  tvalid tready tdata tuser        value, result_kind
//
//  Accumulate and binarise requests are taken one per cycle; either kind
//  waits for the output register to have room.
//  A request with action 0 and tlast starts the sweep: a threshold with an
//  empty class is skipped, else it is scored with three passes of the
//  7-digit long multiplier; s_tready is low.
//  After rst the 256-entry histogram is cleared, s_tready low.
//  The sweep zeroes each bin as it reads it, so no clear follows a search.
//  Output stalls hold m_ and back-pressure s_ through s_tready.
// ----------------------------------------------------------------------------
module otsu_threshold_binarizer_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [otsu_pkg::PIX_W-1:0] s_tdata,   // [7:0] pixel
  input  logic                       s_tuser,   // [0] action
  input  logic                       s_tlast,   // last pixel of the image
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [otsu_pkg::PIX_W-1:0] m_tdata,   // [7:0] value
  output logic                       m_tuser    // [0] result_kind
);

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_SWEEP = 2'b10
  } top_state_t;

  top_state_t state;

  logic                       accept;
  logic                       out_free;
  logic                       acc_req;
  logic                       bin_req;
  logic                       sweep_start;
  logic                       sw_ack;
  logic                       hist_busy;
  logic [otsu_pkg::PIX_W-1:0] chosen_level;

  logic [otsu_pkg::CNT_W-1:0] rd_data;
  logic [otsu_pkg::CNT_W-1:0] n;
  logic [otsu_pkg::SUM_W-1:0] s;
  otsu_pkg::sw_mem_t          sw_mem;
  otsu_pkg::sw_res_t          sw_res;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_RUN) && !hist_busy && out_free;
  assign accept   = s_tvalid && s_tready;
  assign acc_req  = accept && (s_tuser == otsu_pkg::ACT_ACC);
  assign bin_req  = accept && (s_tuser == otsu_pkg::ACT_BIN);
  // the threshold goes out once the output register has room
  assign sw_ack   = (state == ST_SWEEP) && sw_res.done && out_free;

  otsu_hist u_hist (
    .clk     (clk),
    .rst     (rst),
    .acc_req (acc_req),
    .pixel   (s_tdata),
    .clr     (sw_ack),
    .mem     (sw_mem),
    .rd_data (rd_data),
    .n       (n),
    .s       (s),
    .busy    (hist_busy)
  );

  otsu_sweep u_sweep (
    .clk     (clk),
    .rst     (rst),
    .start   (sweep_start),
    .ack     (sw_ack),
    .n       (n),
    .s       (s),
    .rd_data (rd_data),
    .mem     (sw_mem),
    .res     (sw_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      sweep_start  <= 1'b0;
      chosen_level <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // the registered start lets the last bin write land before the sweep reads
      sweep_start <= acc_req && s_tlast;
      unique case (state)
        ST_RUN: begin
          if (acc_req && s_tlast) begin
            state <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          if (sw_ack) begin
            state        <= ST_RUN;
            chosen_level <= sw_res.level;
          end
        end
        default: state <= ST_RUN;
      endcase
      if (sw_ack || bin_req) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sw_ack) begin
      m_tuser <= otsu_pkg::KIND_THRESH;
      m_tdata <= sw_res.level;
    end else if (bin_req) begin
      m_tuser <= otsu_pkg::KIND_PIXEL;
      m_tdata <= (s_tdata > chosen_level) ? otsu_pkg::PIX_HIGH : otsu_pkg::PIX_LOW;
    end
  end

endmodule

FILE: tb/sv/tb_otsu_threshold_binarizer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_otsu_threshold_binarizer_top : self-checking bench for the Otsu binariser
// Streams images and binarise requests through the block. A local histogram
// search predicts each threshold and binarised pixel. Results are checked in
// order, with random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_otsu_threshold_binarizer_top;

  localparam int CNT_LIMIT = (1 << 21) - 1;
  localparam int PIXEL_CAP = (otsu_pkg::MAX_PIXELS < CNT_LIMIT) ? otsu_pkg::MAX_PIXELS
                                                                : CNT_LIMIT;
  localparam int RANDOM_REQUESTS = 1950;

  typedef struct packed {
    logic                       kind;
    logic [otsu_pkg::PIX_W-1:0] value;
  } outcome_t;

  // shapes of grey-level content for random images
  typedef enum int {MIX_FLAT, MIX_TWO_PEAKS, MIX_NARROW, MIX_EDGES} pixel_mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       s_tvalid;
  logic                       s_tready;
  logic [otsu_pkg::PIX_W-1:0] s_tdata;   // [7:0] pixel
  logic                       s_tuser;   // [0] action
  logic                       s_tlast;   // last pixel of the image
  logic                       m_tvalid;
  logic                       m_tready;
  logic [otsu_pkg::PIX_W-1:0] m_tdata;   // [7:0] value
  logic                       m_tuser;   // [0] result_kind

  // histogram mirror and held threshold
  logic [20:0]                grey_hist [otsu_pkg::LEVELS];
  logic [20:0]                grey_count;
  logic [28:0]                grey_sum;
  logic [otsu_pkg::PIX_W-1:0] held_threshold;

  outcome_t awaited_outputs[$];

  int  fail_count;
  int  thresholds_checked;
  int  pixels_checked;
  int  images_sent;
  int  hold_cycles;     // receiver hold-off, counted down by the receiver
  bit  sender_calm;     // no idling on the request side
  bit  receiver_calm;   // no idling on the result side

  otsu_threshold_binarizer_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Exact Otsu search over the mirrored histogram. Scores d^2/den are
  // compared by cross multiplication; the first best threshold wins, and a
  // split with an empty class is never a candidate.
  function automatic logic [otsu_pkg::PIX_W-1:0] otsu_level();
    logic [63:0]                n, s, w1, s1, w2, a, b, d, den, best_d, best_den;
    logic [191:0]               lhs, rhs;
    logic [otsu_pkg::PIX_W-1:0] best_t;
    n = 64'(grey_count);
    s = 64'(grey_sum);
    w1 = '0;
    s1 = '0;
    best_d = '0;
    best_den = 64'd1;
    best_t = '0;
    for (int t = 0; t < otsu_pkg::LEVELS; t++) begin
      w1 += 64'(grey_hist[t]);
      s1 += 64'(grey_hist[t]) * 64'(t);
      if (w1 == 0 || w1 >= n) continue;
      w2  = n - w1;
      a   = s * w1;
      b   = n * s1;
      d   = (a >= b) ? a - b : b - a;
      den = w1 * w2;
      lhs = 192'(d) * 192'(d) * 192'(best_den);
      rhs = 192'(best_d) * 192'(best_d) * 192'(den);
      if (lhs > rhs) begin
        best_d   = d;
        best_den = den;
        best_t   = otsu_pkg::PIX_W'(t);
      end
    end
    return best_t;
  endfunction

  task automatic clear_histogram();
    foreach (grey_hist[i]) grey_hist[i] = '0;
    grey_count = '0;
    grey_sum   = '0;
  endtask

  // Apply one accepted request to the mirror and queue what it should yield.
  task automatic model_request(input logic act, input logic [otsu_pkg::PIX_W-1:0] pix,
                               input logic lst);
    int lv;
    if (act == otsu_pkg::ACT_BIN) begin
      awaited_outputs.push_back('{otsu_pkg::KIND_PIXEL,
                                  (pix > held_threshold) ? otsu_pkg::PIX_HIGH
                                                         : otsu_pkg::PIX_LOW});
      return;
    end
    if (grey_count < PIXEL_CAP) begin
      lv = (int'(pix) >= otsu_pkg::LEVELS) ? otsu_pkg::LEVELS - 1 : int'(pix);
      grey_hist[lv] = grey_hist[lv] + 21'd1;
      grey_count    = grey_count + 21'd1;
      grey_sum      = grey_sum + 29'(lv);
    end
    if (lst) begin
      held_threshold = otsu_level();
      clear_histogram();
      awaited_outputs.push_back('{otsu_pkg::KIND_THRESH, held_threshold});
      images_sent++;
    end
  endtask

  // One request: optional idle cycles, then hold it until taken.
  task automatic send_request(input logic act, input logic [otsu_pkg::PIX_W-1:0] pix,
                              input logic lst);
    while (!sender_calm && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      s_tdata  <= otsu_pkg::PIX_W'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= pix;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    model_request(act, pix, lst);
  endtask

  // Sender pauses until every queued result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_outputs.size() != 0) @(posedge clk);
  endtask

  function automatic logic [otsu_pkg::PIX_W-1:0] draw_pixel(input pixel_mix_t mix,
                                                            input int c1, input int c2,
                                                            input int spread);
    int v;
    case (mix)
      MIX_FLAT:      v = $urandom_range(255);
      MIX_TWO_PEAKS: v = ($urandom_range(1) ? c1 : c2) + $urandom_range(2 * spread) - spread;
      MIX_NARROW:    v = c1 + $urandom_range(spread);
      default: begin
        if ($urandom_range(9) == 0) v = $urandom_range(255);
        else v = $urandom_range(1) ? 255 : 0;
      end
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return otsu_pkg::PIX_W'(v);
  endfunction

  // Binarise probes cluster round the held threshold to hit both sides of it.
  function automatic logic [otsu_pkg::PIX_W-1:0] probe_pixel();
    int v;
    if ($urandom_range(1)) v = $urandom_range(255);
    else v = int'(held_threshold) + $urandom_range(2) - 1;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return otsu_pkg::PIX_W'(v);
  endfunction

  // Extremes, single-pixel and single-level images, ties, and stray tlast
  // on binarise requests.
  task automatic test_directed_cases();
    // threshold is zero after reset
    send_request(otsu_pkg::ACT_BIN, 8'd0, 1'b0);
    send_request(otsu_pkg::ACT_BIN, 8'd1, 1'b0);
    send_request(otsu_pkg::ACT_BIN, 8'd255, 1'b1);
    // one pixel only: no split has both classes filled
    send_request(otsu_pkg::ACT_ACC, 8'd255, 1'b1);
    // single level
    send_request(otsu_pkg::ACT_ACC, 8'd77, 1'b0);
    send_request(otsu_pkg::ACT_ACC, 8'd77, 1'b0);
    send_request(otsu_pkg::ACT_ACC, 8'd77, 1'b1);
    // levels 0 and 255 only
    send_request(otsu_pkg::ACT_ACC, 8'd0, 1'b0);
    send_request(otsu_pkg::ACT_ACC, 8'd255, 1'b0);
    send_request(otsu_pkg::ACT_ACC, 8'd0, 1'b0);
    send_request(otsu_pkg::ACT_ACC, 8'd255, 1'b1);
    send_request(otsu_pkg::ACT_BIN, 8'd0, 1'b0);
    send_request(otsu_pkg::ACT_BIN, 8'd1, 1'b0);
    // equal scores for every split between 10 and 20: the lowest wins
    send_request(otsu_pkg::ACT_ACC, 8'd10, 1'b0);
    send_request(otsu_pkg::ACT_ACC, 8'd20, 1'b1);
    send_request(otsu_pkg::ACT_BIN, 8'd10, 1'b0);
    send_request(otsu_pkg::ACT_BIN, 8'd11, 1'b1);
    // three clusters, with a binarise request in the middle of the image
    send_request(otsu_pkg::ACT_ACC, 8'd0, 1'b0);
    send_request(otsu_pkg::ACT_ACC, 8'd128, 1'b0);
    send_request(otsu_pkg::ACT_BIN, 8'd170, 1'b0);
    send_request(otsu_pkg::ACT_ACC, 8'd129, 1'b0);
    send_request(otsu_pkg::ACT_ACC, 8'd254, 1'b1);
    send_request(otsu_pkg::ACT_BIN, 8'd254, 1'b0);
    send_request(otsu_pkg::ACT_BIN, 8'd255, 1'b0);
    wait_drained();
  endtask

  // Long receiver hold-off: the output fills, then s_tready must drop.
  task automatic test_output_backpressure();
    for (int i = 0; i < 8; i++) begin
      send_request(otsu_pkg::ACT_ACC, otsu_pkg::PIX_W'($urandom), 1'(i == 7));
    end
    wait_drained();
    // hold off only once the search is over, so the binarise results pile up
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) send_request(otsu_pkg::ACT_BIN, probe_pixel(), 1'($urandom));
    wait_drained();
  endtask

  // Random images with random content, binarise bursts after each, stray
  // binarise requests inside images, and the odd calm stretch.
  task automatic test_random_images();
    int         sent;
    int         rounds;
    int         size;
    int         burst;
    int         c1, c2, spread;
    pixel_mix_t mix;
    sent   = 0;
    rounds = 0;
    while (sent < RANDOM_REQUESTS) begin
      sender_calm   = (rounds == 9 || rounds == 10);
      receiver_calm = sender_calm;
      case ($urandom_range(19))
        0:       size = $urandom_range(600, 201);
        1, 2, 3: size = $urandom_range(200, 61);
        default: size = $urandom_range(60, 1);
      endcase
      mix    = pixel_mix_t'($urandom_range(3));
      c1     = $urandom_range(255);
      c2     = $urandom_range(255);
      spread = $urandom_range(20);
      for (int i = 0; i < size; i++) begin
        if ($urandom_range(9) == 0) begin
          send_request(otsu_pkg::ACT_BIN, probe_pixel(), 1'($urandom));
          sent++;
        end
        send_request(otsu_pkg::ACT_ACC, draw_pixel(mix, c1, c2, spread), 1'(i == size - 1));
        sent++;
      end
      burst = $urandom_range(30);
      for (int i = 0; i < burst; i++) begin
        send_request(otsu_pkg::ACT_BIN, probe_pixel(), 1'($urandom));
        sent++;
      end
      if ($urandom_range(4) == 0) wait_drained();
      rounds++;
    end
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    wait_drained();
  endtask

  // result side: random stalls, plus the counted hold-off
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else if (receiver_calm) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 33);
      end
    end
  end

  // compare every taken result with the oldest outstanding one
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_outputs.size() == 0) begin
        $error("unexpected result: result_kind %0d value %0d", m_tuser, m_tdata);
        fail_count++;
      end else begin
        want = awaited_outputs.pop_front();
        if (m_tuser !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, m_tuser);
          fail_count++;
        end
        if (m_tdata !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, m_tdata);
          fail_count++;
        end
        if (want.kind == otsu_pkg::KIND_THRESH) thresholds_checked++;
        else pixels_checked++;
      end
    end
  end

  initial begin
    #150_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = otsu_pkg::ACT_ACC;
    s_tlast  = 1'b0;
    held_threshold = '0;
    clear_histogram();
    fail_count = 0;
    thresholds_checked = 0;
    pixels_checked = 0;
    images_sent = 0;
    hold_cycles = 0;
    sender_calm = 1'b0;
    receiver_calm = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_output_backpressure();
    test_random_images();

    repeat (200) @(posedge clk);
    $display("Covered %0d images and %0d thresholds,", images_sent, thresholds_checked);
    $display("plus %0d binarised pixels under random idling and a long output stall.",
             pixels_checked);
    if (fail_count == 0 && awaited_outputs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
